// ----- rtl/core/cbpa_pkg.sv -----
// Shared types and constants for the chunked byte-presence averager.
package cbpa_pkg;

    // Item kinds carried on the input channel.
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_BYTE  = 1'b1;

    // Fixed sizes of the byte histogram and the buffer length limit.
    localparam int BYTE_VALUES = 256;
    localparam int BYTE_W      = 8;
    localparam int COUNT_W     = 9;
    localparam int LEN_W       = 17;
    localparam int SUM_W       = 25;

    localparam logic [LEN_W-1:0] MAX_BUFFER_BYTES = 17'd65536;
    localparam logic [LEN_W-1:0] SAMPLE_RESET     = 17'd512;

    // Input beat.
    typedef struct packed {
        logic                 kind;
        logic [BYTE_W-1:0]    byte_value;
        logic [LEN_W-1:0]     buffer_length;
    } item_t;

    // Output beat.
    typedef struct packed {
        logic [COUNT_W-1:0]   average_present;
        logic [LEN_W-1:0]     chunk_count;
    } result_t;

    // Control from the chunk sequencer to the histogram.
    typedef struct packed {
        logic                 upd;
        logic                 clear;
        logic [BYTE_W-1:0]    addr;
        logic [COUNT_W-1:0]   thr;
    } hist_ctl_t;

endpackage

// ----- rtl/core/cbpa_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
module cbpa_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port; data appears the cycle after the address.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/cbpa_hist.sv -----
// Byte histogram: RAM with per-entry valid bits, read-modify-write and forwarding.
module cbpa_hist
    import cbpa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  logic [BYTE_W-1:0] rd_addr,
    input  hist_ctl_t         ctl,
    output logic              present_inc
);

    logic [BYTE_VALUES-1:0] valid_reg, valid_next;
    logic                   fwd_valid_reg, fwd_valid_next;
    logic [BYTE_W-1:0]      fwd_addr_reg, fwd_addr_next;
    logic [COUNT_W-1:0]     fwd_data_reg, fwd_data_next;
    logic [COUNT_W-1:0]     rdata;
    logic [COUNT_W-1:0]     cur_count;
    logic [COUNT_W-1:0]     new_count;
    logic                   wr_en;

    cbpa_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (BYTE_VALUES)
    ) u_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (ctl.addr),
        .wdata (new_count),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rdata)
    );

    // Current count: an entry not written in this chunk reads as zero, and a
    // write at the edge of the read is taken from the forwarding register.
    always_comb
    begin
        if (!valid_reg[ctl.addr])
        begin
            cur_count = '0;
        end
        else if (fwd_valid_reg && (fwd_addr_reg == ctl.addr))
        begin
            cur_count = fwd_data_reg;
        end
        else
        begin
            cur_count = rdata;
        end
    end

    // Saturating increment and threshold detection.
    always_comb
    begin
        new_count   = cur_count + COUNT_W'(1);
        wr_en       = ctl.upd && (cur_count < ctl.thr);
        present_inc = wr_en && (new_count >= ctl.thr);
    end

    // Valid bits and forwarding state.
    always_comb
    begin
        valid_next     = valid_reg;
        fwd_valid_next = fwd_valid_reg;
        fwd_addr_next  = fwd_addr_reg;
        fwd_data_next  = fwd_data_reg;
        if (wr_en)
        begin
            valid_next[ctl.addr] = 1'b1;
            fwd_valid_next       = 1'b1;
            fwd_addr_next        = ctl.addr;
            fwd_data_next        = new_count;
        end
        if (ctl.clear)
        begin
            valid_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg     <= valid_next;
            fwd_valid_reg <= fwd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_addr_reg <= fwd_addr_next;
        fwd_data_reg <= fwd_data_next;
    end

endmodule

// ----- rtl/core/cbpa_div.sv -----
// Restoring divider giving a 9-bit quotient, one bit per cycle.
module cbpa_div
    import cbpa_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [SUM_W-1:0]   dividend,
    input  logic [LEN_W-1:0]   divisor,
    output logic               busy,
    output logic               done,
    output logic [COUNT_W-1:0] quotient
);

    localparam int STEP_W = $clog2(COUNT_W);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [SUM_W-1:0]    rem_reg, rem_next;
    logic [SUM_W-1:0]    dsh_reg, dsh_next;
    logic [COUNT_W-1:0]  q_reg, q_next;

    // One quotient bit per cycle, divisor shifted down from the top bit.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        q_next    = q_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = STEP_W'(COUNT_W - 1);
            rem_next  = dividend;
            dsh_next  = {divisor, {(SUM_W - LEN_W){1'b0}}};
            q_next    = '0;
        end
        else if (busy_reg)
        begin
            if (rem_reg >= dsh_reg)
            begin
                rem_next = rem_reg - dsh_reg;
                q_next   = {q_reg[COUNT_W-2:0], 1'b1};
            end
            else
            begin
                q_next   = {q_reg[COUNT_W-2:0], 1'b0};
            end
            dsh_next = dsh_reg >> 1;
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                step_next = step_reg - STEP_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        q_reg   <= q_next;
    end

    assign busy     = busy_reg | done_reg;
    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

// ----- rtl/core/chunked_byte_presence_averager.sv -----
// Top level of the chunked byte-presence averager.
//
//  Channel  | Signals                         | Beat contents
//  ---------+---------------------------------+---------------------------------
//  item     | item_valid, item_stall, item    | kind, byte_value, buffer_length
//  result   | result_valid, result_stall,     | average_present, chunk_count
//           | result                          |
//  config   | cfg_wen, cfg_wdata              | nominal chunk length in bytes
//
// Data beats are taken one per cycle while item_stall is low: the histogram read
// is issued as the beat is taken and the count is written back the next cycle,
// with forwarding between neighbouring beats that hit the same byte value.
// The last byte of a buffer, or a start beat of zero length, starts a division of
// the present sum by the chunk count, one quotient bit per cycle; input stalls
// from that launch through the quotient bits and the output load, and then until
// the result beat is taken.
// Reset is asynchronous and active low; no clearing pass is needed, as the
// histogram entries carry valid bits that are cleared at each chunk opening.
// A stalled result holds its value while the input side keeps stalling.
module chunked_byte_presence_averager
    import cbpa_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  item_t            item,
    output logic             result_valid,
    input  logic             result_stall,
    output result_t          result,
    input  logic             cfg_wen,
    input  logic [LEN_W-1:0] cfg_wdata
);

    logic               in_accept;
    logic               out_accept;

    logic [LEN_W-1:0]   sample_reg;
    logic               s1_valid_reg;
    item_t              s1_item_reg;

    logic [LEN_W-1:0]   active_reg, active_next;
    logic [LEN_W-1:0]   buf_left_reg, buf_left_next;
    logic [LEN_W-1:0]   chunk_left_reg, chunk_left_next;
    logic [COUNT_W-1:0] thr_reg, thr_next;
    logic [COUNT_W-1:0] present_reg, present_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [LEN_W-1:0]   done_cnt_reg, done_cnt_next;
    logic [LEN_W-1:0]   count_hold_reg;

    logic               res_valid_reg;
    result_t            res_reg;

    hist_ctl_t          hctl;
    logic               present_inc;

    logic               launch;
    logic [SUM_W-1:0]   launch_sum;
    logic [LEN_W-1:0]   launch_n;

    logic               div_busy;
    logic               div_done;
    logic [COUNT_W-1:0] div_q;

    logic               open_en;
    logic [LEN_W-1:0]   open_rem;
    logic [LEN_W-1:0]   open_s;
    logic [LEN_W-1:0]   open_len;
    logic [LEN_W-1:0]   start_s;
    logic [LEN_W-1:0]   start_len;
    logic [COUNT_W-1:0] present_upd;
    logic [LEN_W-1:0]   buf_dec;
    logic [LEN_W-1:0]   chunk_dec;

    assign in_accept  = item_valid && !item_stall;
    assign out_accept = res_valid_reg && !result_stall;

    // No new beat while a result is being formed or waits to be taken.
    assign item_stall = launch || div_busy || res_valid_reg;

    // Sample size register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_reg <= SAMPLE_RESET;
        end
        else if (cfg_wen)
        begin
            sample_reg <= cfg_wdata;
        end
    end

    // Stage register holding the beat whose histogram read is in flight.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_item_reg <= item;
        end
    end

    cbpa_hist u_hist (
        .clk         (clk),
        .rst_n       (rst_n),
        .rd_en       (in_accept),
        .rd_addr     (item.byte_value),
        .ctl         (hctl),
        .present_inc (present_inc)
    );

    // Start beat: zero sample size acts as one, and the length is clamped.
    always_comb
    begin
        start_s   = (sample_reg == '0) ? LEN_W'(1) : sample_reg;
        start_len = (s1_item_reg.buffer_length > MAX_BUFFER_BYTES) ?
                    MAX_BUFFER_BYTES : s1_item_reg.buffer_length;
        present_upd = present_reg + COUNT_W'(present_inc);
        buf_dec     = buf_left_reg - LEN_W'(1);
        chunk_dec   = (chunk_left_reg != '0) ? (chunk_left_reg - LEN_W'(1)) : '0;
    end

    // Chunk sequencer.
    always_comb
    begin
        active_next     = active_reg;
        buf_left_next   = buf_left_reg;
        chunk_left_next = chunk_left_reg;
        thr_next        = thr_reg;
        present_next    = present_reg;
        sum_next        = sum_reg;
        done_cnt_next   = done_cnt_reg;
        hctl            = '0;
        hctl.addr       = s1_item_reg.byte_value;
        hctl.thr        = thr_reg;
        launch          = 1'b0;
        launch_sum      = '0;
        launch_n        = LEN_W'(1);
        open_en         = 1'b0;
        open_rem        = '0;
        open_s          = active_reg;

        if (s1_valid_reg)
        begin
            if (s1_item_reg.kind == KIND_START)
            begin
                active_next   = start_s;
                done_cnt_next = '0;
                sum_next      = '0;
                buf_left_next = start_len;
                open_en       = 1'b1;
                open_rem      = start_len;
                open_s        = start_s;
                if (start_len == '0)
                begin
                    launch = 1'b1;
                end
            end
            else if (buf_left_reg != '0)
            begin
                hctl.upd        = 1'b1;
                present_next    = present_upd;
                buf_left_next   = buf_dec;
                chunk_left_next = chunk_dec;
                if (chunk_dec == '0)
                begin
                    sum_next      = sum_reg + SUM_W'(present_upd);
                    done_cnt_next = done_cnt_reg + LEN_W'(1);
                    if (buf_dec == '0)
                    begin
                        launch     = 1'b1;
                        launch_sum = sum_next;
                        launch_n   = done_cnt_next;
                    end
                    else
                    begin
                        open_en  = 1'b1;
                        open_rem = buf_dec;
                    end
                end
            end
        end

        // Chunk opening: the last chunk takes the rest once two would not fit.
        open_len = ({1'b0, open_rem} < {open_s, 1'b0}) ? open_rem : open_s;
        if (open_en)
        begin
            chunk_left_next = open_len;
            thr_next        = open_len[LEN_W-1:BYTE_W];
            present_next    = '0;
            hctl.clear      = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg     <= '0;
            buf_left_reg   <= '0;
            chunk_left_reg <= '0;
            thr_reg        <= '0;
            present_reg    <= '0;
            sum_reg        <= '0;
            done_cnt_reg   <= '0;
        end
        else
        begin
            active_reg     <= active_next;
            buf_left_reg   <= buf_left_next;
            chunk_left_reg <= chunk_left_next;
            thr_reg        <= thr_next;
            present_reg    <= present_next;
            sum_reg        <= sum_next;
            done_cnt_reg   <= done_cnt_next;
        end
    end

    cbpa_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (launch),
        .dividend (launch_sum),
        .divisor  (launch_n),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    // Chunk count travels alongside the division.
    always_ff @(posedge clk)
    begin
        if (launch)
        begin
            count_hold_reg <= launch_n;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (div_done)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (out_accept)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (div_done)
        begin
            res_reg.average_present <= div_q;
            res_reg.chunk_count     <= count_hold_reg;
        end
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    // A result is only started when the divider and output are free.
    a_launch_free: assert property (@(posedge clk) disable iff (!rst_n)
        launch |-> (!div_busy && !res_valid_reg))
        else $error("result started while divider or output busy");

    // The divider finishes only into an empty output register.
    a_done_empty: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> !res_valid_reg)
        else $error("division finished over a waiting result");

    // A result never carries a zero chunk count or an average above 256.
    a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> ((res_reg.chunk_count != '0)
                           && (res_reg.average_present <= COUNT_W'(BYTE_VALUES))))
        else $error("result out of range");

    // A taken beat is processed in the following cycle.
    a_stage_follow: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> s1_valid_reg)
        else $error("accepted beat not staged");

endmodule
